/* design/clns_pkg.sv */
// ----------------------------------------------------------------------------
// clns_pkg
// Shared types and constants for the character LCD nibble sequencer.
// ----------------------------------------------------------------------------
package clns_pkg;

	// request kinds as they arrive on the input stream
	typedef enum logic [2:0] {
		REQ_CMD   = 3'd0,
		REQ_DATA  = 3'd1,
		REQ_PUTC  = 3'd2,
		REQ_GOTO  = 3'd3,
		REQ_CLEAR = 3'd4,
		REQ_HOME  = 3'd5,
		REQ_INIT  = 3'd6,
		REQ_LIGHT = 3'd7
	} req_t;

	// job kinds queued between front and back
	typedef enum logic [1:0] {
		JOB_BYTE  = 2'd0,
		JOB_INIT  = 2'd1,
		JOB_LIGHT = 2'd2
	} job_kind_t;

	// wait codes
	localparam logic [2:0] WAIT_NONE  = 3'd0;
	localparam logic [2:0] WAIT_50US  = 3'd1;
	localparam logic [2:0] WAIT_CMD   = 3'd2;
	localparam logic [2:0] WAIT_5MS   = 3'd3;
	localparam logic [2:0] WAIT_100US = 3'd4;
	localparam logic [2:0] WAIT_30MS  = 3'd5;

	// register-select levels
	localparam logic RS_CMD  = 1'b0;
	localparam logic RS_DATA = 1'b1;

	// LCD command bytes
	localparam logic [7:0] CMD_CLEAR    = 8'h01;
	localparam logic [7:0] CMD_HOME     = 8'h02;
	localparam logic [7:0] CMD_ENTRY    = 8'h06;
	localparam logic [7:0] CMD_DISPLAY  = 8'h0C;
	localparam logic [7:0] CMD_FUNCTION = 8'h28;
	localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
	localparam logic [7:0] ROW0_BASE    = 8'h80;
	localparam logic [7:0] ROW1_BASE    = 8'hC0;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

	// power-up nibbles
	localparam logic [3:0] NIB_WAKE   = 4'h3;
	localparam logic [3:0] NIB_4BIT   = 4'h2;

	// init sequence: last step index, first step of the command bytes
	localparam logic [3:0] INIT_LAST_STEP = 4'd14;
	localparam logic [3:0] INIT_CMD_STEP  = 4'd5;

	localparam logic [5:0] DISPLAY_LENGTH_RST = 6'd16;

	// one queued job
	typedef struct packed {
		job_kind_t  kind;
		logic [7:0] data;      // byte to send (extra command for init)
		logic       rs;
		logic       bl_first;  // backlight level on the first result
		logic       bl_rest;   // backlight level on the remaining results
	} job_t;

	// head of queue as seen by the back end
	typedef struct packed {
		logic valid;
		job_t job;
	} job_head_t;

endpackage

/* design/clns_front.sv */
// ----------------------------------------------------------------------------
// clns_front
// Request decoder: keeps cursor, backlight and row-base state, turns each
// request into one queued job (a byte, the init sequence or a backlight set).
// ----------------------------------------------------------------------------
module clns_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [5:0]        cfg_wdata,
	input  logic              accept,
	input  logic [2:0]        req_type,
	input  logic [7:0]        value,
	input  logic [5:0]        col,
	input  logic [1:0]        row,
	output clns_pkg::job_t    job
);

	logic [5:0] display_length_q;
	logic [1:0] cursor_row_q;
	logic       backlight_q;
	logic       rows_ext_q;

	logic [1:0] tgt_row;
	logic [7:0] tgt_col;
	logic [7:0] row_base;
	logic [7:0] goto_cmd;
	logic       set_cursor;
	logic [1:0] next_row;

	// target of a goto or a newline
	always_comb begin
		if (clns_pkg::req_t'(req_type) == clns_pkg::REQ_GOTO) begin
			tgt_row = row;
			tgt_col = {2'b00, col};
		end else begin
			tgt_row = cursor_row_q + 2'd1;
			tgt_col = 8'd0;
		end
	end

	// row base address; rows 2 and 3 sit after the visible length once init ran
	always_comb begin
		unique case (tgt_row)
			2'd0: row_base = clns_pkg::ROW0_BASE;
			2'd1: row_base = clns_pkg::ROW1_BASE;
			2'd2: row_base = rows_ext_q ? clns_pkg::ROW0_BASE + {2'b00, display_length_q} : 8'd0;
			default: row_base = rows_ext_q ? clns_pkg::ROW1_BASE + {2'b00, display_length_q} : 8'd0;
		endcase
		goto_cmd = clns_pkg::CMD_SET_DDRAM | (row_base + tgt_col);
	end

	// classify the request
	always_comb begin
		job.kind     = clns_pkg::JOB_BYTE;
		job.data     = value;
		job.rs       = clns_pkg::RS_CMD;
		job.bl_first = backlight_q;
		job.bl_rest  = backlight_q;
		set_cursor   = 1'b0;
		next_row     = cursor_row_q;
		unique case (clns_pkg::req_t'(req_type))
			clns_pkg::REQ_CMD: begin
			end
			clns_pkg::REQ_DATA: begin
				job.rs = clns_pkg::RS_DATA;
			end
			clns_pkg::REQ_PUTC: begin
				if (value == clns_pkg::CHAR_NEWLINE) begin
					job.data   = goto_cmd;
					set_cursor = 1'b1;
					next_row   = tgt_row;
				end else begin
					job.rs = clns_pkg::RS_DATA;
				end
			end
			clns_pkg::REQ_GOTO: begin
				job.data   = goto_cmd;
				set_cursor = 1'b1;
				next_row   = tgt_row;
			end
			clns_pkg::REQ_CLEAR: begin
				job.data   = clns_pkg::CMD_CLEAR;
				set_cursor = 1'b1;
				next_row   = 2'd0;
			end
			clns_pkg::REQ_HOME: begin
				job.data   = clns_pkg::CMD_HOME;
				set_cursor = 1'b1;
				next_row   = 2'd0;
			end
			clns_pkg::REQ_INIT: begin
				job.kind    = clns_pkg::JOB_INIT;
				job.bl_rest = 1'b0;
			end
			clns_pkg::REQ_LIGHT: begin
				job.kind     = clns_pkg::JOB_LIGHT;
				job.bl_first = value[0];
				job.bl_rest  = value[0];
			end
			default: begin
			end
		endcase
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			display_length_q <= clns_pkg::DISPLAY_LENGTH_RST;
		end else if (cfg_we) begin
			display_length_q <= cfg_wdata;
		end
	end

	// state updated on every accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_row_q <= 2'd0;
			backlight_q  <= 1'b0;
			rows_ext_q   <= 1'b0;
		end else if (accept) begin
			if (set_cursor) begin
				cursor_row_q <= next_row;
			end
			if (clns_pkg::req_t'(req_type) == clns_pkg::REQ_INIT) begin
				backlight_q <= 1'b0;
				rows_ext_q  <= 1'b1;
			end else if (clns_pkg::req_t'(req_type) == clns_pkg::REQ_LIGHT) begin
				backlight_q <= value[0];
			end
		end
	end

endmodule

/* design/clns_fifo.sv */
// ----------------------------------------------------------------------------
// clns_fifo
// Short job queue between the request decoder and the nibble sequencer.
// ----------------------------------------------------------------------------
module clns_fifo #(
	parameter int DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  clns_pkg::job_t       push_job,
	input  logic                 pop,
	output logic                 full,
	output clns_pkg::job_head_t  head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	clns_pkg::job_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head.valid = (count_q != '0);
	assign head.job   = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* design/clns_back.sv */
// ----------------------------------------------------------------------------
// clns_back
// Nibble sequencer: steps through the head job one bus transfer per cycle while
// not stalled, and holds each result in the output register until it is taken.
// ----------------------------------------------------------------------------
module clns_back (
	input  logic                clk,
	input  logic                arst_n,
	input  clns_pkg::job_head_t head,
	output logic                pop,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [15:0]         m_tdata,   // nibble[3:0], strobe_res[4], backlight[5],
	                                       // wait_code[8:6], zero fill
	output logic                m_tuser,   // reg_select
	output logic                m_tlast
);

	logic [3:0] step_q;
	logic       valid_q;
	logic [3:0] nib_q;
	logic       rs_q;
	logic       strobe_q;
	logic       bl_q;
	logic [2:0] wait_q;
	logic       last_q;

	logic       fire;
	logic [3:0] cmd_off;
	logic [7:0] cur_byte;
	logic       hi_half;
	logic [3:0] nib_d;
	logic       rs_d;
	logic       strobe_d;
	logic       bl_d;
	logic [2:0] wait_d;
	logic       last_d;

	assign fire = head.valid && (!valid_q || m_tready);
	assign pop  = fire && last_d;

	// byte being sent: the job's byte, or the next command in the init command phase
	always_comb begin
		cmd_off = step_q - clns_pkg::INIT_CMD_STEP;
		unique case (cmd_off[3:1])
			3'd0:    cur_byte = clns_pkg::CMD_FUNCTION;
			3'd1:    cur_byte = clns_pkg::CMD_DISPLAY;
			3'd2:    cur_byte = clns_pkg::CMD_ENTRY;
			3'd3:    cur_byte = clns_pkg::CMD_CLEAR;
			default: cur_byte = head.job.data;
		endcase
		if (head.job.kind != clns_pkg::JOB_INIT) begin
			cur_byte = head.job.data;
		end
		hi_half = (head.job.kind == clns_pkg::JOB_INIT) ? !cmd_off[0] : (step_q == 4'd0);
	end

	// result fields for the current step
	always_comb begin
		rs_d     = clns_pkg::RS_CMD;
		strobe_d = 1'b1;
		bl_d     = head.job.bl_rest;
		nib_d    = hi_half ? cur_byte[7:4] : cur_byte[3:0];
		if (hi_half) begin
			wait_d = clns_pkg::WAIT_NONE;
		end else if (cur_byte <= clns_pkg::CMD_HOME && rs_d == clns_pkg::RS_CMD &&
			(head.job.kind == clns_pkg::JOB_INIT || head.job.rs == clns_pkg::RS_CMD)) begin
			wait_d = clns_pkg::WAIT_CMD;
		end else begin
			wait_d = clns_pkg::WAIT_50US;
		end
		last_d = 1'b0;
		unique case (head.job.kind)
			clns_pkg::JOB_BYTE: begin
				rs_d   = head.job.rs;
				last_d = (step_q != 4'd0);
			end
			clns_pkg::JOB_LIGHT: begin
				nib_d    = 4'd0;
				strobe_d = 1'b0;
				wait_d   = clns_pkg::WAIT_NONE;
				last_d   = 1'b1;
			end
			clns_pkg::JOB_INIT: begin
				last_d = (step_q == clns_pkg::INIT_LAST_STEP);
				unique case (step_q)
					4'd0: begin
						nib_d    = 4'd0;
						strobe_d = 1'b0;
						bl_d     = head.job.bl_first;
						wait_d   = clns_pkg::WAIT_30MS;
					end
					4'd1: begin
						nib_d  = clns_pkg::NIB_WAKE;
						wait_d = clns_pkg::WAIT_5MS;
					end
					4'd2: begin
						nib_d  = clns_pkg::NIB_WAKE;
						wait_d = clns_pkg::WAIT_100US;
					end
					4'd3: begin
						nib_d  = clns_pkg::NIB_WAKE;
						wait_d = clns_pkg::WAIT_50US;
					end
					4'd4: begin
						nib_d  = clns_pkg::NIB_4BIT;
						wait_d = clns_pkg::WAIT_50US;
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	// step counter within the head job
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= 4'd0;
		end else if (fire) begin
			step_q <= last_d ? 4'd0 : step_q + 4'd1;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (fire) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (fire) begin
			nib_q    <= nib_d;
			rs_q     <= rs_d;
			strobe_q <= strobe_d;
			bl_q     <= bl_d;
			wait_q   <= wait_d;
			last_q   <= last_d;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {7'd0, wait_q, bl_q, strobe_q, nib_q};
	assign m_tuser  = rs_q;
	assign m_tlast  = last_q;

endmodule

/* design/char_lcd_nibble_sequencer.sv */
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer
// Turns LCD requests into 4-bit bus transfers with strobe and wait codes.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ stream: s_tuser is the request kind, s_tdata
//   carries value, col and row. Each request yields one or more bus
//   transfers on the m_ stream; m_tlast marks the final one of a request.
//   Byte requests (command, data, put char, goto, clear, home) give two
//   transfers, backlight gives one, init gives fifteen.
//   The back end emits one transfer per cycle while the receiver keeps up,
//   so byte requests sustain one request every two transfers; init holds
//   the back end for its fifteen transfers. A request's first transfer is
//   registered in the job queue and then in the output register.
//   The job queue (QUEUE_DEPTH entries) decouples the decoder from the
//   sequencer: requests are taken while the queue has room, even while a
//   finished transfer waits on a stalled receiver.
//   cfg_we/cfg_wdata write display_length; write only while idle.
//   Reset clears the queue, cursor row, backlight and row-base mode, and
//   sets display_length to 16.
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [5:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // value[7:0], col[13:8], row[15:14]
	input  logic [2:0]  s_tuser,   // req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // nibble[3:0], strobe_res[4], backlight[5],
	                               // wait_code[8:6], zero fill
	output logic        m_tuser,   // reg_select
	output logic        m_tlast
);

	logic                accept;
	logic                full;
	logic                pop;
	clns_pkg::job_t      job;
	clns_pkg::job_head_t head;

	assign s_tready = !full;
	assign accept   = s_tvalid && s_tready;

	// request decoder
	clns_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.accept    (accept),
		.req_type  (s_tuser),
		.value     (s_tdata[7:0]),
		.col       (s_tdata[13:8]),
		.row       (s_tdata[15:14]),
		.job       (job)
	);

	// job queue
	clns_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.push_job (job),
		.pop      (pop),
		.full     (full),
		.head     (head)
	);

	// nibble sequencer
	clns_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

/* test/lcd_bus_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_bus_checker
// Watches both streams of the LCD nibble sequencer, predicts every bus
// transfer from the accepted requests and compares the transfers that come
// out, field by field and in order.
// ----------------------------------------------------------------------------
module lcd_bus_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [5:0]  cfg_wdata,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,   // value[7:0], col[13:8], row[15:14]
	input  logic [2:0]  s_tuser,   // req_type
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,   // nibble[3:0], strobe_res[4], backlight[5],
	                               // wait_code[8:6], zero fill
	input  logic        m_tuser,   // reg_select
	input  logic        m_tlast,
	output int          xfer_pending,
	output int          fail_count
);

	// one expected bus transfer
	typedef struct packed {
		logic [3:0] nib;
		logic       rs;
		logic       strb;
		logic       bl;
		logic [2:0] wait_c;
		logic       is_last;
	} lcd_xfer_t;

	lcd_xfer_t  lcd_xfer_q[$];
	lcd_xfer_t  oldest;

	// shadow of the block's state and register
	logic [5:0] disp_len;
	logic [7:0] cur_col;
	logic [1:0] cur_row;
	logic       light;
	logic       ext_rows;
	int         errs;

	task automatic push_xfer(input logic [3:0] nib, input logic rs, input logic strb,
			input logic [2:0] wait_c);
		lcd_xfer_t x;
		x.nib     = strb ? nib : 4'h0;
		x.rs      = strb ? rs : clns_pkg::RS_CMD;
		x.strb    = strb;
		x.bl      = light;
		x.wait_c  = wait_c;
		x.is_last = 1'b0;
		lcd_xfer_q.push_back(x);
	endtask

	// high nibble, then low nibble; short commands need the long wait
	task automatic push_byte(input logic [7:0] b, input logic rs);
		push_xfer(b[7:4], rs, 1'b1, clns_pkg::WAIT_NONE);
		push_xfer(b[3:0], rs, 1'b1,
			(rs == clns_pkg::RS_CMD && b <= 8'd2) ? clns_pkg::WAIT_CMD : clns_pkg::WAIT_50US);
	endtask

	function automatic logic [7:0] row_base(input logic [1:0] r);
		case (r)
			2'd0: row_base = clns_pkg::ROW0_BASE;
			2'd1: row_base = clns_pkg::ROW1_BASE;
			2'd2: row_base = ext_rows ? clns_pkg::ROW0_BASE + {2'b00, disp_len} : 8'h00;
			default: row_base = ext_rows ? clns_pkg::ROW1_BASE + {2'b00, disp_len} : 8'h00;
		endcase
	endfunction

	task automatic push_goto(input logic [7:0] c, input logic [1:0] r);
		logic [7:0] addr;
		addr = row_base(r) + c;
		push_byte(clns_pkg::CMD_SET_DDRAM | addr, clns_pkg::RS_CMD);
		cur_col = c;
		cur_row = r;
	endtask

	// expected transfers of one request, last one flagged
	task automatic predict_transfers(input clns_pkg::req_t kind, input logic [7:0] val,
			input logic [5:0] col, input logic [1:0] row);
		case (kind) inside
			clns_pkg::REQ_CMD:  push_byte(val, clns_pkg::RS_CMD);
			clns_pkg::REQ_DATA: push_byte(val, clns_pkg::RS_DATA);
			clns_pkg::REQ_PUTC: begin
				if (val == clns_pkg::CHAR_NEWLINE) begin
					push_goto(8'h00, cur_row + 2'd1);
				end else begin
					cur_col = cur_col + 8'd1;
					push_byte(val, clns_pkg::RS_DATA);
				end
			end
			clns_pkg::REQ_GOTO: push_goto({2'b00, col}, row);
			clns_pkg::REQ_CLEAR, clns_pkg::REQ_HOME: begin
				push_byte((kind == clns_pkg::REQ_CLEAR) ? clns_pkg::CMD_CLEAR
					: clns_pkg::CMD_HOME, clns_pkg::RS_CMD);
				cur_col = 8'h00;
				cur_row = 2'd0;
			end
			clns_pkg::REQ_INIT: begin
				ext_rows = 1'b1;
				// first transfer still shows the old backlight level
				push_xfer(4'h0, clns_pkg::RS_CMD, 1'b0, clns_pkg::WAIT_30MS);
				light = 1'b0;
				push_xfer(clns_pkg::NIB_WAKE, clns_pkg::RS_CMD, 1'b1, clns_pkg::WAIT_5MS);
				push_xfer(clns_pkg::NIB_WAKE, clns_pkg::RS_CMD, 1'b1, clns_pkg::WAIT_100US);
				push_xfer(clns_pkg::NIB_WAKE, clns_pkg::RS_CMD, 1'b1, clns_pkg::WAIT_50US);
				push_xfer(clns_pkg::NIB_4BIT, clns_pkg::RS_CMD, 1'b1, clns_pkg::WAIT_50US);
				push_byte(clns_pkg::CMD_FUNCTION, clns_pkg::RS_CMD);
				push_byte(clns_pkg::CMD_DISPLAY, clns_pkg::RS_CMD);
				push_byte(clns_pkg::CMD_ENTRY, clns_pkg::RS_CMD);
				push_byte(clns_pkg::CMD_CLEAR, clns_pkg::RS_CMD);
				push_byte(val, clns_pkg::RS_CMD);
			end
			default: begin
				light = val[0];
				push_xfer(4'h0, clns_pkg::RS_CMD, 1'b0, clns_pkg::WAIT_NONE);
			end
		endcase
		lcd_xfer_q[lcd_xfer_q.size() - 1].is_last = 1'b1;
	endtask

	task automatic check_field(input string what, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			errs++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, act_v);
		end
	endtask

	// requests are predicted before transfers are popped at the same edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disp_len = clns_pkg::DISPLAY_LENGTH_RST;
			cur_col  = 8'h00;
			cur_row  = 2'd0;
			light    = 1'b0;
			ext_rows = 1'b0;
			errs     = 0;
			lcd_xfer_q.delete();
			xfer_pending <= 0;
			fail_count   <= 0;
		end else begin
			if (cfg_we)
				disp_len = cfg_wdata;
			if (s_tvalid && s_tready)
				predict_transfers(clns_pkg::req_t'(s_tuser), s_tdata[7:0], s_tdata[13:8],
					s_tdata[15:14]);
			if (m_tvalid && m_tready) begin
				if (lcd_xfer_q.size() == 0) begin
					errs++;
					$display("%0t: unexpected transfer, expected none, %s %h rs %b last %b",
						$time, "actual tdata", m_tdata, m_tuser, m_tlast);
				end else begin
					oldest = lcd_xfer_q.pop_front();
					check_field("nibble", int'(oldest.nib), int'(m_tdata[3:0]));
					check_field("strobe_res", int'(oldest.strb), int'(m_tdata[4]));
					check_field("backlight", int'(oldest.bl), int'(m_tdata[5]));
					check_field("wait_code", int'(oldest.wait_c), int'(m_tdata[8:6]));
					check_field("reg_select", int'(oldest.rs), int'(m_tuser));
					check_field("last", int'(oldest.is_last), int'(m_tlast));
				end
			end
			xfer_pending <= lcd_xfer_q.size();
			fail_count   <= errs;
		end
	end

endmodule

/* test/char_lcd_nibble_sequencer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer_tb
// Drives LCD requests into the sequencer: a directed pass over every request
// kind and corner, then random requests under several display lengths with
// random gaps on both streams, a long receiver stall and idle pauses.
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer_tb;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_ITEMS = 23;
	localparam int LONG_STALL  = 120;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [5:0]  cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic [2:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	int          xfer_pending;
	int          fail_count;
	int          cycle_count = 0;

	// pacing controls for the sender and the receiver process
	logic        src_steady  = 1'b0;
	logic        sink_steady = 1'b0;
	logic        hold_off_req = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	char_lcd_nibble_sequencer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	lcd_bus_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.m_tlast      (m_tlast),
		.xfer_pending (xfer_pending),
		.fail_count   (fail_count)
	);

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("char_lcd_nibble_sequencer_tb: errors");
			$finish;
		end
	end

	// receiver: random gap before each transfer, one long stall on request
	initial begin : bus_sink
		int   gap;
		logic stall_taken;
		stall_taken = 1'b0;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off_req && !stall_taken) begin
				stall_taken = 1'b1;
				gap = LONG_STALL;
			end else begin
				gap = sink_steady ? 0 : $urandom_range(0, 4);
			end
			if (gap != 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
		end
	end

	// one request transfer, after a random gap
	task automatic send_req(input clns_pkg::req_t kind, input logic [7:0] val,
			input logic [5:0] col, input logic [1:0] row);
		int gap;
		gap = src_steady ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {row, col, val};
		do @(posedge clk); while (!(s_tvalid && s_tready));
	endtask

	task automatic wait_all_transfers();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (xfer_pending != 0) @(posedge clk);
	endtask

	task automatic write_display_length(input logic [5:0] len);
		cfg_we    <= 1'b1;
		cfg_wdata <= len;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// mostly byte traffic; init is rare since it is long
	task automatic send_random_req();
		int             pick;
		logic [7:0]     val;
		clns_pkg::req_t kind;
		pick = $urandom_range(0, 99);
		val  = 8'($urandom_range(0, 255));
		if (pick < 18) begin
			kind = clns_pkg::REQ_CMD;
			if ($urandom_range(0, 2) == 0)
				val = 8'($urandom_range(0, 3));
		end else if (pick < 36) begin
			kind = clns_pkg::REQ_DATA;
		end else if (pick < 58) begin
			kind = clns_pkg::REQ_PUTC;
			if ($urandom_range(0, 3) == 0)
				val = clns_pkg::CHAR_NEWLINE;
		end else if (pick < 76) begin
			kind = clns_pkg::REQ_GOTO;
		end else if (pick < 83) begin
			kind = clns_pkg::REQ_CLEAR;
		end else if (pick < 90) begin
			kind = clns_pkg::REQ_HOME;
		end else if (pick < 95) begin
			kind = clns_pkg::REQ_LIGHT;
		end else begin
			kind = clns_pkg::REQ_INIT;
		end
		send_req(kind, val, 6'($urandom_range(0, 63)), 2'($urandom_range(0, 3)));
	endtask

	initial begin : stimulus
		logic [5:0] lengths[6];
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = 6'd0;
		s_tvalid  = 1'b0;
		s_tdata   = 16'h0000;
		s_tuser   = clns_pkg::REQ_CMD;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed pass at the reset display length
		send_req(clns_pkg::REQ_LIGHT, 8'h01, 6'd0, 2'd0);
		send_req(clns_pkg::REQ_CMD, 8'h00, 6'd0, 2'd0);
		send_req(clns_pkg::REQ_CMD, 8'h02, 6'd0, 2'd0);
		send_req(clns_pkg::REQ_CMD, 8'h03, 6'd0, 2'd0);
		send_req(clns_pkg::REQ_CMD, 8'hFF, 6'd0, 2'd0);
		send_req(clns_pkg::REQ_DATA, 8'h00, 6'd0, 2'd0);
		send_req(clns_pkg::REQ_DATA, 8'hFF, 6'd0, 2'd0);
		send_req(clns_pkg::REQ_PUTC, 8'h41, 6'd0, 2'd0);
		send_req(clns_pkg::REQ_PUTC, clns_pkg::CHAR_NEWLINE, 6'd0, 2'd0);
		// rows 2 and 3 have base zero before init
		send_req(clns_pkg::REQ_GOTO, 8'h00, 6'd63, 2'd3);
		send_req(clns_pkg::REQ_GOTO, 8'h00, 6'd5, 2'd2);
		send_req(clns_pkg::REQ_PUTC, clns_pkg::CHAR_NEWLINE, 6'd0, 2'd0);
		send_req(clns_pkg::REQ_PUTC, clns_pkg::CHAR_NEWLINE, 6'd0, 2'd0);
		send_req(clns_pkg::REQ_CLEAR, 8'h00, 6'd0, 2'd0);
		send_req(clns_pkg::REQ_HOME, 8'h00, 6'd0, 2'd0);
		send_req(clns_pkg::REQ_LIGHT, 8'hFE, 6'd0, 2'd0);
		send_req(clns_pkg::REQ_LIGHT, 8'h01, 6'd0, 2'd0);
		// init with the backlight on, then the extended row bases
		send_req(clns_pkg::REQ_INIT, 8'hFF, 6'd0, 2'd0);
		send_req(clns_pkg::REQ_GOTO, 8'h00, 6'd39, 2'd2);
		send_req(clns_pkg::REQ_GOTO, 8'h00, 6'd63, 2'd3);
		send_req(clns_pkg::REQ_GOTO, 8'h00, 6'd0, 2'd1);
		send_req(clns_pkg::REQ_PUTC, clns_pkg::CHAR_NEWLINE, 6'd0, 2'd0);
		send_req(clns_pkg::REQ_INIT, 8'h00, 6'd0, 2'd0);
		send_req(clns_pkg::REQ_CMD, 8'h01, 6'h3F, 2'd3);
		wait_all_transfers();

		// random phases, one display length each
		lengths = '{6'd40, 6'd1, 6'd63, 6'd0, 6'd0, 6'd16};
		lengths[4] = 6'($urandom_range(1, 62));
		for (int ph = 0; ph < 6; ph++) begin
			write_display_length(lengths[ph]);
			src_steady  = (ph == 3);
			sink_steady = (ph == 3);
			if (ph == 1)
				hold_off_req = 1'b1;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// sender pause until the output side has drained
				if (ph == 2 && i == PHASE_ITEMS / 2)
					wait_all_transfers();
				send_random_req();
			end
			wait_all_transfers();
		end

		repeat (20) @(posedge clk);
		if (fail_count == 0 && xfer_pending == 0)
			$display("char_lcd_nibble_sequencer_tb: clean");
		else
			$display("char_lcd_nibble_sequencer_tb: errors");
		$finish;
	end

endmodule
